@@ rtl/tdm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, sizes and codes for the table-driven automaton matcher.
package tdm_pkg;

	localparam int NUM_STATES  = 16;
	localparam int SYMBOL_BITS = 8;
	localparam int NUM_SYMBOLS = 1 << SYMBOL_BITS;
	localparam int STATE_BITS  = $clog2(NUM_STATES);
	localparam int TBL_DEPTH   = NUM_STATES * NUM_SYMBOLS;
	localparam int TBL_AW      = $clog2(TBL_DEPTH);
	localparam int STATE_W     = 4;
	localparam int SYM_W       = 8;
	localparam int ENTRY_W     = STATE_W + 1;

	typedef enum logic [2:0] {
		REQ_WR_TRANS  = 3'd0,
		REQ_WR_ACCEPT = 3'd1,
		REQ_WR_ALPHA  = 3'd2,
		REQ_SYMBOL    = 3'd3,
		REQ_END       = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_ALPHA = 2'd1,
		ERR_TRANS = 2'd2
	} err_t;

	// Position of a string walk: the current state and the latched error.
	typedef struct packed {
		logic [STATE_W-1:0] state;
		err_t               err;
	} walk_t;

	// Transition table entry.
	typedef struct packed {
		logic               valid;
		logic [STATE_W-1:0] next;
	} entry_t;

	// Status of the power-up clearing sweep.
	typedef struct packed {
		logic              busy;
		logic [TBL_AW-1:0] addr;
	} clr_t;

	function automatic logic state_in_range(input logic [STATE_W-1:0] s);
		return 32'(s) < NUM_STATES;
	endfunction

	function automatic logic sym_in_range(input logic [SYM_W-1:0] s);
		return 32'(s) < NUM_SYMBOLS;
	endfunction

endpackage

@@ rtl/tdm_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module tdm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/tdm_clear.sv @@
`timescale 1ns / 1ps
// Clearing sweep over the table memories after reset.
module tdm_clear import tdm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	output clr_t clr
);

	logic [TBL_AW:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (!cnt_q[TBL_AW]) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign clr.busy = !cnt_q[TBL_AW];
	assign clr.addr = cnt_q[TBL_AW-1:0];

endmodule

@@ rtl/tdm_step.sv @@
`timescale 1ns / 1ps
// Next walk position from a registered word and the table lookups it issued.
module tdm_step import tdm_pkg::*; (
	input  logic [2:0]         req,
	input  logic               sym_ok,
	input  walk_t              walk,
	input  logic               alpha_hit,
	input  entry_t             entry,
	input  logic [STATE_W-1:0] start_state,
	output walk_t              walk_next
);

	always_comb begin
		walk_next = walk;
		case (req)
			REQ_SYMBOL: begin
				if (walk.err == ERR_NONE) begin
					if (!sym_ok || !alpha_hit) begin
						walk_next.err = ERR_ALPHA;
					end else if (!state_in_range(walk.state) || !entry.valid) begin
						walk_next.err = ERR_TRANS;
					end else begin
						walk_next.state = entry.next;
					end
				end
			end
			REQ_END: begin
				walk_next.state = start_state;
				walk_next.err   = ERR_NONE;
			end
			default: walk_next = walk;
		endcase
	end

endmodule

@@ rtl/table_driven_dfa_matcher.sv @@
`timescale 1ns / 1ps
// Top level of the programmable table-driven automaton matcher.
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------------------------
//   input    | in_valid / in_ready    | req_type, from_state, symbol, to_state, mark
//   result   | out_valid / out_ready  | accepted, error_code, final_state
//   config   | cfg_we (no wait)       | cfg_wdata -> start state
//
// One input word is taken every cycle while in_ready is high. The table and alphabet
// memories are read at the accept edge; the next cycle resolves the step and feeds
// the new state straight back into the next word's table address, so the memory
// read loop sets the rate. An end-of-string word loads the result register when it
// leaves the register stage. After reset a clearing sweep over every table address
// empties both memories; in_ready stays low until it finishes. in_ready also drops
// while an end word waits for a full result register to drain.
module table_driven_dfa_matcher import tdm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [STATE_W-1:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         req_type,
	input  logic [STATE_W-1:0] from_state,
	input  logic [SYM_W-1:0]   symbol,
	input  logic [STATE_W-1:0] to_state,
	input  logic               mark,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               accepted,
	output logic [1:0]         error_code,
	output logic [STATE_W-1:0] final_state
);

	clr_t               clr;
	logic [STATE_W-1:0] start_state_q;
	walk_t              walk_q;
	logic [NUM_STATES-1:0] accept_q;

	// Registered word in flight.
	logic               valid_s1;
	logic [2:0]         req_s1;
	logic               sym_ok_s1;
	walk_t              walk_s1;

	logic               out_valid_q;
	logic               accepted_q;
	err_t               error_q;
	logic [STATE_W-1:0] final_q;

	walk_t              walk_next;
	walk_t              walk_eff;
	logic               accept_in;
	logic               adv_s1;
	logic               res_load;
	logic               sym_ok;

	logic               tbl_we;
	logic [TBL_AW-1:0]  tbl_waddr;
	entry_t             tbl_wdata;
	logic [TBL_AW-1:0]  tbl_raddr;
	entry_t             tbl_rdata;
	logic               alpha_we;
	logic [SYMBOL_BITS-1:0] alpha_waddr;
	logic               alpha_wdata;
	logic               alpha_rdata;

	tdm_clear u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clr)
	);

	// A word leaves the register stage unless it is an end word facing a full
	// result register that is not being emptied this cycle.
	assign res_load  = valid_s1 && (req_s1 == REQ_END) && (!out_valid_q || out_ready);
	assign adv_s1    = valid_s1 && ((req_s1 != REQ_END) || !out_valid_q || out_ready);
	assign in_ready  = !clr.busy && (!valid_s1 || adv_s1);
	assign accept_in = in_valid && in_ready;
	assign sym_ok    = sym_in_range(symbol);

	tdm_step u_step (
		.req         (req_s1),
		.sym_ok      (sym_ok_s1),
		.walk        (walk_s1),
		.alpha_hit   (alpha_rdata),
		.entry       (tbl_rdata),
		.start_state (start_state_q),
		.walk_next   (walk_next)
	);

	// The word being accepted sees the outcome of the word still in the register
	// stage; this is the feedback that lets symbols run back to back.
	assign walk_eff = valid_s1 ? walk_next : walk_q;

	// Memory ports: the clearing sweep owns the write side until it is done.
	always_comb begin
		if (clr.busy) begin
			tbl_we      = 1'b1;
			tbl_waddr   = clr.addr;
			tbl_wdata   = '0;
			alpha_we    = 1'b1;
			alpha_waddr = clr.addr[SYMBOL_BITS-1:0];
			alpha_wdata = 1'b0;
		end else begin
			tbl_we      = accept_in && (req_type == REQ_WR_TRANS) &&
				state_in_range(from_state) && sym_ok &&
				(!mark || state_in_range(to_state));
			tbl_waddr   = {from_state[STATE_BITS-1:0], symbol[SYMBOL_BITS-1:0]};
			tbl_wdata   = mark ? entry_t'{valid: 1'b1, next: to_state} : '0;
			alpha_we    = accept_in && (req_type == REQ_WR_ALPHA) && sym_ok;
			alpha_waddr = symbol[SYMBOL_BITS-1:0];
			alpha_wdata = mark;
		end
	end

	assign tbl_raddr = {walk_eff.state[STATE_BITS-1:0], symbol[SYMBOL_BITS-1:0]};

	tdm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TBL_DEPTH)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (accept_in),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	tdm_ram #(
		.WIDTH (1),
		.DEPTH (NUM_SYMBOLS)
	) u_alpha_ram (
		.clk   (clk),
		.we    (alpha_we),
		.waddr (alpha_waddr),
		.wdata (alpha_wdata),
		.re    (accept_in),
		.raddr (symbol[SYMBOL_BITS-1:0]),
		.rdata (alpha_rdata)
	);

	// Start state register; a write also restarts the walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_state_q <= '0;
		end else if (cfg_we) begin
			start_state_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '{state: '0, err: ERR_NONE};
		end else if (cfg_we) begin
			walk_q <= '{state: cfg_wdata, err: ERR_NONE};
		end else if (adv_s1) begin
			walk_q <= walk_next;
		end
	end

	// Accept marks are few enough to live in flip-flops.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accept_q <= '0;
		end else if (accept_in && (req_type == REQ_WR_ACCEPT) &&
				state_in_range(from_state)) begin
			accept_q[from_state[STATE_BITS-1:0]] <= mark;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			req_s1    <= req_type;
			sym_ok_s1 <= sym_ok;
			walk_s1   <= walk_eff;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			accepted_q <= (walk_s1.err == ERR_NONE) && state_in_range(walk_s1.state) &&
				accept_q[walk_s1.state[STATE_BITS-1:0]];
			error_q    <= walk_s1.err;
			final_q    <= walk_s1.state;
		end
	end

	assign out_valid   = out_valid_q;
	assign accepted    = accepted_q;
	assign error_code  = error_q;
	assign final_state = final_q;

endmodule

@@ sim/table_driven_dfa_matcher_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the table-driven automaton matcher: programs tables, walks strings.
module table_driven_dfa_matcher_tb import tdm_pkg::*; ();

	localparam int          DRAIN_CYCLES  = 6;
	localparam int          LIVE_N        = 4;
	localparam logic [2:0]  REQ_UNUSED_LO = 3'd5;
	localparam logic [2:0]  REQ_UNUSED_HI = 3'd7;

	// What one end-of-string word reports.
	typedef struct {
		logic               accepted;
		err_t               error_code;
		logic [STATE_W-1:0] final_state;
	} verdict_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_we      = 1'b0;
	logic [STATE_W-1:0] cfg_wdata   = '0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic [2:0]         req_type    = '0;
	logic [STATE_W-1:0] from_state  = '0;
	logic [SYM_W-1:0]   symbol      = '0;
	logic [STATE_W-1:0] to_state    = '0;
	logic               mark        = 1'b0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic               accepted;
	logic [1:0]         error_code;
	logic [STATE_W-1:0] final_state;

	// Shadow copy of the automaton, advanced on every accepted input word.
	entry_t             trans_tbl [NUM_STATES * NUM_SYMBOLS];
	logic               accept_mark [NUM_STATES];
	logic               alpha_mark [NUM_SYMBOLS];
	logic [STATE_W-1:0] start_reg;
	logic [STATE_W-1:0] walk_state;
	err_t               walk_err;

	verdict_t           pending_verdicts [$];
	int                 mismatch_count = 0;
	int                 words_sent     = 0;
	int                 send_idle_pct  = 0;
	int                 recv_stall_pct = 0;
	int                 hold_cycles    = 0;

	// The automaton that the random strings run on: its states and alphabet.
	logic [STATE_W-1:0] live_states [LIVE_N];
	logic [SYM_W-1:0]   live_syms [LIVE_N];

	table_driven_dfa_matcher u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.from_state  (from_state),
		.symbol      (symbol),
		.to_state    (to_state),
		.mark        (mark),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.accepted    (accepted),
		.error_code  (error_code),
		.final_state (final_state)
	);

	always #6 clk = ~clk;

	// Applies one word to the shadow automaton; an end word queues its verdict.
	function automatic void advance_automaton(input logic [2:0] rq, input logic [STATE_W-1:0] fs,
			input logic [SYM_W-1:0] sy, input logic [STATE_W-1:0] ts, input logic mk);
		int       fsi;
		int       syi;
		int       tsi;
		entry_t   ent;
		verdict_t v;
		fsi = int'(fs);
		syi = int'(sy);
		tsi = int'(ts);
		case (rq)
			REQ_WR_TRANS: begin
				if (fsi < NUM_STATES && syi < NUM_SYMBOLS) begin
					if (!mk)
						trans_tbl[fsi * NUM_SYMBOLS + syi] = '0;
					else if (tsi < NUM_STATES)
						trans_tbl[fsi * NUM_SYMBOLS + syi] = '{valid: 1'b1, next: ts};
				end
			end
			REQ_WR_ACCEPT: begin
				if (fsi < NUM_STATES)
					accept_mark[fsi] = mk;
			end
			REQ_WR_ALPHA: begin
				if (syi < NUM_SYMBOLS)
					alpha_mark[syi] = mk;
			end
			REQ_SYMBOL: begin
				// Once an error is latched the rest of the string is ignored.
				if (walk_err == ERR_NONE) begin
					if (syi >= NUM_SYMBOLS || !alpha_mark[syi]) begin
						walk_err = ERR_ALPHA;
					end else if (int'(walk_state) >= NUM_STATES) begin
						walk_err = ERR_TRANS;
					end else begin
						ent = trans_tbl[int'(walk_state) * NUM_SYMBOLS + syi];
						if (!ent.valid)
							walk_err = ERR_TRANS;
						else
							walk_state = ent.next;
					end
				end
			end
			REQ_END: begin
				v.accepted    = (walk_err == ERR_NONE && int'(walk_state) < NUM_STATES) ?
				                accept_mark[int'(walk_state)] : 1'b0;
				v.error_code  = walk_err;
				v.final_state = walk_state;
				pending_verdicts.push_back(v);
				walk_state = start_reg;
				walk_err   = ERR_NONE;
			end
			default: begin
			end
		endcase
	endfunction

	// Input side: every accepted word goes through the shadow automaton.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			advance_automaton(req_type, from_state, symbol, to_state, mark);
	end

	// Result side: each accepted result is checked against the oldest verdict.
	always @(posedge clk) begin : check_results
		verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("result with no end-of-string word outstanding");
				mismatch_count++;
			end else begin
				want = pending_verdicts.pop_front();
				if (accepted !== want.accepted) begin
					$error("accepted: expected %0d, got %0d", want.accepted, accepted);
					mismatch_count++;
				end
				if (error_code !== want.error_code) begin
					$error("error_code: expected %0d, got %0d", want.error_code, error_code);
					mismatch_count++;
				end
				if (final_state !== want.final_state) begin
					$error("final_state: expected %0d, got %0d", want.final_state, final_state);
					mismatch_count++;
				end
			end
		end
	end

	// Receiver: a long hold-off when one is requested, random stalls otherwise.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Offers one word after random idle cycles and returns at the edge that takes it.
	task automatic send_word(input logic [2:0] rq, input logic [STATE_W-1:0] fs,
			input logic [SYM_W-1:0] sy, input logic [STATE_W-1:0] ts, input logic mk);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= rq;
		from_state <= fs;
		symbol     <= sy;
		to_state   <= ts;
		mark       <= mk;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
	endtask

	// Symbol and end words carry random values in the fields they do not use.
	task automatic send_symbol(input logic [SYM_W-1:0] sy);
		send_word(REQ_SYMBOL, STATE_W'($urandom), sy, STATE_W'($urandom), 1'($urandom));
	endtask

	task automatic send_end();
		send_word(REQ_END, STATE_W'($urandom), SYM_W'($urandom), STATE_W'($urandom),
		          1'($urandom));
	endtask

	// Stops offering words and waits until every verdict has come back, then
	// waits out DRAIN_CYCLES for a symbol word that may still be resolving.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// A start-state write also restarts the string in progress.
	task automatic set_start_state(input logic [STATE_W-1:0] s);
		wait_drained();
		@(negedge clk);
		cfg_we     <= 1'b1;
		cfg_wdata  <= s;
		start_reg  = s;
		walk_state = s;
		walk_err   = ERR_NONE;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Builds a small automaton: four states, four symbols, mostly full transitions.
	task automatic program_automaton();
		int               i;
		int               j;
		int               roll;
		logic [STATE_W-1:0] st;
		roll = $urandom_range(2);
		st   = (roll == 0) ? '0 : (roll == 1) ? '1 : STATE_W'($urandom);
		set_start_state(st);
		live_states[0] = st;
		for (i = 1; i < LIVE_N; i++)
			live_states[i] = STATE_W'($urandom);
		for (i = 0; i < LIVE_N; i++) begin
			live_syms[i] = SYM_W'($urandom);
			send_word(REQ_WR_ALPHA, STATE_W'($urandom), live_syms[i], STATE_W'($urandom), 1'b1);
		end
		for (i = 0; i < LIVE_N; i++) begin
			for (j = 0; j < LIVE_N; j++) begin
				if ($urandom_range(7) != 0)
					send_word(REQ_WR_TRANS, live_states[i], live_syms[j],
					          live_states[$urandom_range(LIVE_N - 1)], 1'b1);
				else
					send_word(REQ_WR_TRANS, live_states[i], live_syms[j],
					          STATE_W'($urandom), 1'b0);
			end
		end
		for (i = 0; i < LIVE_N; i++)
			send_word(REQ_WR_ACCEPT, live_states[i], SYM_W'($urandom), STATE_W'($urandom),
			          1'($urandom));
	endtask

	// One string over the live alphabet, with the odd stray symbol, table rewrite
	// or unused request mixed in, closed by an end word.
	task automatic send_random_string(input int max_len);
		int len;
		int k;
		int roll;
		len = $urandom_range(max_len);
		for (k = 0; k < len; k++) begin
			roll = $urandom_range(99);
			if (roll < 3)
				send_word(3'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO)), STATE_W'($urandom),
				          SYM_W'($urandom), STATE_W'($urandom), 1'($urandom));
			else if (roll < 6)
				send_word(REQ_WR_TRANS, live_states[$urandom_range(LIVE_N - 1)],
				          live_syms[$urandom_range(LIVE_N - 1)],
				          live_states[$urandom_range(LIVE_N - 1)], ($urandom_range(3) != 0));
			else if (roll < 8)
				send_word(REQ_WR_ACCEPT, live_states[$urandom_range(LIVE_N - 1)],
				          SYM_W'($urandom), STATE_W'($urandom), 1'($urandom));
			else if (roll < 9)
				send_word(REQ_WR_ALPHA, STATE_W'($urandom), live_syms[$urandom_range(LIVE_N - 1)],
				          STATE_W'($urandom), ($urandom_range(3) != 0));
			else if (roll < 12)
				send_symbol(SYM_W'($urandom));
			else
				send_symbol(live_syms[$urandom_range(LIVE_N - 1)]);
		end
		send_end();
	endtask

	// Extreme fields, every request type, both error kinds, empty strings.
	task automatic test_directed_walks();
		send_end();                                          // empty string, start rejects
		send_word(REQ_WR_ACCEPT, 4'd0, 8'h00, 4'd0, 1'b1);
		send_end();                                          // empty string, start accepts
		send_word(REQ_WR_ACCEPT, 4'd15, 8'hFF, 4'd15, 1'b1);
		send_word(REQ_WR_ALPHA, 4'd0, 8'h00, 4'd0, 1'b1);
		send_word(REQ_WR_ALPHA, 4'd15, 8'hFF, 4'd15, 1'b1);
		send_word(REQ_WR_TRANS, 4'd0, 8'h00, 4'd15, 1'b1);
		send_word(REQ_WR_TRANS, 4'd15, 8'hFF, 4'd0, 1'b1);
		send_symbol(8'h00);
		send_symbol(8'hFF);
		send_end();                                          // back in state 0, accepted
		send_symbol(8'h00);
		send_symbol(8'h00);                                  // missing transition in state 15
		send_symbol(8'hFF);                                  // ignored after the error
		send_end();
		send_symbol(8'h5A);                                  // outside the alphabet
		send_end();
		send_word(REQ_WR_TRANS, 4'd0, 8'h00, 4'd15, 1'b0);  // invalidate the entry
		send_symbol(8'h00);
		send_end();
		send_word(3'(REQ_UNUSED_LO), 4'd15, 8'hFF, 4'd15, 1'b1);
		send_word(3'(REQ_UNUSED_LO + 3'd1), 4'd15, 8'hFF, 4'd15, 1'b1);
		send_word(3'(REQ_UNUSED_HI), 4'd15, 8'hFF, 4'd15, 1'b1);
		send_end();
		send_word(REQ_WR_ALPHA, 4'd0, 8'hFF, 4'd0, 1'b0);
		send_symbol(8'hFF);
		send_end();
	endtask

	// Rewriting the start state drops a string in progress, error included.
	task automatic test_start_rewrite();
		send_symbol(8'h5A);
		set_start_state(4'd15);
		send_end();
		send_word(REQ_WR_ALPHA, 4'd3, 8'h00, 4'd3, 1'b1);
		send_symbol(8'h00);                                  // no entry from state 15
		set_start_state(4'd0);
		send_end();
	endtask

	task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n_words);
		int target;
		send_idle_pct  = snd_pct;
		recv_stall_pct = rcv_pct;
		program_automaton();
		target = words_sent + n_words;
		while (words_sent < target)
			send_random_string(7);
	endtask

	// Receiver holds off while short strings keep coming, so the result path
	// fills and the input side has to stall.
	task automatic test_result_backpressure();
		int target;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		program_automaton();
		hold_cycles = 250;
		target = words_sent + 60;
		while (words_sent < target)
			send_random_string(2);
	endtask

	// Sender pauses now and then until every verdict is back.
	task automatic test_sender_pause();
		int n;
		send_idle_pct  = 14;
		recv_stall_pct = 30;
		program_automaton();
		for (n = 0; n < 8; n++) begin
			send_random_string(5);
			if (n % 3 == 1)
				wait_drained();
		end
	endtask

	initial begin : run_tests
		int i;
		for (i = 0; i < NUM_STATES * NUM_SYMBOLS; i++)
			trans_tbl[i] = '0;
		for (i = 0; i < NUM_STATES; i++)
			accept_mark[i] = 1'b0;
		for (i = 0; i < NUM_SYMBOLS; i++)
			alpha_mark[i] = 1'b0;
		start_reg  = '0;
		walk_state = '0;
		walk_err   = ERR_NONE;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_walks();
		test_start_rewrite();
		test_random_traffic(0, 0, 85);
		test_random_traffic(54, 0, 85);
		test_random_traffic(0, 54, 85);
		test_random_traffic(14, 14, 85);
		test_result_backpressure();
		test_sender_pause();
		wait_drained();

		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Far beyond the slowest correct run, clearing sweep included.
	initial begin
		#3000000;
		$display("FAILURE");
		$finish;
	end

endmodule

@@ table_driven_dfa_matcher.f @@
rtl/tdm_pkg.sv
rtl/tdm_ram.sv
rtl/tdm_clear.sv
rtl/tdm_step.sv
rtl/table_driven_dfa_matcher.sv
sim/table_driven_dfa_matcher_tb.sv
